// ----- design/ntpdr_pkg.sv -----
`default_nettype none

package ntpdr_pkg;

    // field widths
    localparam int TIME_W  = 33;
    localparam int TOD_W   = 29;
    localparam int PAIR_W  = 7;
    localparam int POS_W   = 4;
    localparam int COUNT_W = 3;
    localparam int DAY_W   = 5;
    localparam int START_W = 6;

    // character codes
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_DOT  = 8'h2E;

    // character positions within the field
    localparam logic [POS_W-1:0] POS_HOUR   = 4'd1;
    localparam logic [POS_W-1:0] POS_MINUTE = 4'd3;
    localparam logic [POS_W-1:0] POS_SECOND = 4'd5;
    localparam logic [POS_W-1:0] POS_DOT    = 4'd6;
    localparam logic [POS_W-1:0] POS_PAIRS  = 4'd6;
    localparam logic [POS_W-1:0] POS_MAX    = 4'd15;

    // day tracking
    localparam logic [START_W-1:0] DAY_UNSET  = 6'd63;
    localparam logic [DAY_W-1:0]   OFFSET_MAX = 5'd31;

    // millisecond scale factors
    localparam logic [TOD_W-1:0]  MS_PER_HOUR   = 29'd3600000;
    localparam logic [TOD_W-1:0]  MS_PER_MINUTE = 29'd60000;
    localparam logic [TOD_W-1:0]  MS_PER_SECOND = 29'd1000;
    localparam logic [TIME_W-1:0] MS_PER_DAY    = 33'd86400000;

    // per-beat control from the input stage
    typedef struct packed {
        logic char_take;
        logic term_take;
    } beat_ctl_t;

    // parsed field as seen on a terminator
    typedef struct packed {
        logic [PAIR_W-1:0] hour;
        logic [PAIR_W-1:0] minute;
        logic [PAIR_W-1:0] second;
        logic [TOD_W-1:0]  tod;
    } field_snap_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    // millisecond weight of each fraction digit
    function automatic logic [6:0] frac_weight(input logic [COUNT_W-1:0] idx);
        logic [6:0] w;
        case (idx)
            3'd0: w = 7'd100;
            3'd1: w = 7'd10;
            3'd2: w = 7'd1;
            default: w = 7'd0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- design/ntpdr_char_parse.sv -----
`default_nettype none

module ntpdr_char_parse #(
    parameter int FRACTION_DIGITS = 3
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire ntpdr_pkg::beat_ctl_t ctl,
    input  wire logic [7:0]          char_code,
    output ntpdr_pkg::field_snap_t   snap
);

    logic [ntpdr_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic [4:0]                    hold_reg, hold_next;
    logic [ntpdr_pkg::PAIR_W-1:0]  hour_reg, hour_next;
    logic [ntpdr_pkg::PAIR_W-1:0]  minute_reg, minute_next;
    logic [ntpdr_pkg::PAIR_W-1:0]  second_reg, second_next;
    logic [ntpdr_pkg::TOD_W-1:0]   tod_reg, tod_next;
    logic [ntpdr_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                          frac_active_reg, frac_active_next;

    logic                          char_digit;
    logic [3:0]                    digit;
    logic [ntpdr_pkg::PAIR_W-1:0]  pair;
    logic                          pairs_done;

    assign char_digit = ntpdr_pkg::is_digit(char_code);
    assign digit      = 4'(char_code - ntpdr_pkg::CHAR_ZERO);
    assign pair       = (hold_reg[4] && char_digit)
                      ? 7'(7'(hold_reg[3:0]) * 7'd10 + 7'(digit)) : 7'd0;

    // next parse state for one character beat; a terminator clears it
    always_comb begin
        pos_next         = pos_reg;
        hold_next        = hold_reg;
        hour_next        = hour_reg;
        minute_next      = minute_reg;
        second_next      = second_reg;
        tod_next         = tod_reg;
        count_next       = count_reg;
        frac_active_next = frac_active_reg;
        if (ctl.term_take) begin
            pos_next         = '0;
            hold_next        = '0;
            hour_next        = '0;
            minute_next      = '0;
            second_next      = '0;
            tod_next         = '0;
            count_next       = '0;
            frac_active_next = 1'b0;
        end else if (ctl.char_take) begin
            if (pos_reg < ntpdr_pkg::POS_PAIRS) begin
                if (!pos_reg[0]) begin
                    hold_next = char_digit ? {1'b1, digit} : 5'd0;
                end else if (pos_reg == ntpdr_pkg::POS_HOUR) begin
                    hour_next = pair;
                    tod_next  = 29'(tod_reg + 29'(pair) * ntpdr_pkg::MS_PER_HOUR);
                end else if (pos_reg == ntpdr_pkg::POS_MINUTE) begin
                    minute_next = pair;
                    tod_next    = 29'(tod_reg + 29'(pair) * ntpdr_pkg::MS_PER_MINUTE);
                end else begin
                    second_next = pair;
                    tod_next    = 29'(tod_reg + 29'(pair) * ntpdr_pkg::MS_PER_SECOND);
                end
            end else if (pos_reg == ntpdr_pkg::POS_DOT) begin
                frac_active_next = (char_code == ntpdr_pkg::CHAR_DOT);
            end else if (frac_active_reg) begin
                if (char_digit) begin
                    if (count_reg < 3'(FRACTION_DIGITS)) begin
                        tod_next   = 29'(tod_reg + 29'(digit)
                                   * 29'(ntpdr_pkg::frac_weight(count_reg)));
                        count_next = 3'(count_reg + 3'd1);
                    end
                end else begin
                    frac_active_next = 1'b0;
                end
            end
            if (pos_reg != ntpdr_pkg::POS_MAX) begin
                pos_next = 4'(pos_reg + 4'd1);
            end
        end
    end

    // parse state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg         <= '0;
            hold_reg        <= '0;
            hour_reg        <= '0;
            minute_reg      <= '0;
            second_reg      <= '0;
            tod_reg         <= '0;
            count_reg       <= '0;
            frac_active_reg <= 1'b0;
        end else begin
            pos_reg         <= pos_next;
            hold_reg        <= hold_next;
            hour_reg        <= hour_next;
            minute_reg      <= minute_next;
            second_reg      <= second_next;
            tod_reg         <= tod_next;
            count_reg       <= count_next;
            frac_active_reg <= frac_active_next;
        end
    end

    // a short field reads as time zero
    assign pairs_done  = (pos_reg >= ntpdr_pkg::POS_PAIRS);
    assign snap.hour   = pairs_done ? hour_reg : '0;
    assign snap.minute = pairs_done ? minute_reg : '0;
    assign snap.second = pairs_done ? second_reg : '0;
    assign snap.tod    = pairs_done ? tod_reg : '0;

endmodule

`default_nettype wire

// ----- design/ntpdr_day_roll.sv -----
`default_nettype none

module ntpdr_day_roll (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire ntpdr_pkg::beat_ctl_t  ctl,
    input  wire logic [4:0]            day_of_month,
    input  wire ntpdr_pkg::field_snap_t snap,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [55:0]                m_tdata
);

    logic [ntpdr_pkg::START_W-1:0] start_day_reg, start_day_next;
    logic [ntpdr_pkg::DAY_W-1:0]   day_offset_reg, day_offset_next;
    logic [ntpdr_pkg::DAY_W-1:0]   prior_reg, prior_next;
    logic [ntpdr_pkg::TIME_W-1:0]  last_reg;
    logic                          out_vld_reg, out_vld_next;

    logic [ntpdr_pkg::TIME_W-1:0]  out_time_reg;
    logic [ntpdr_pkg::PAIR_W-1:0]  out_hour_reg, out_minute_reg, out_second_reg;
    logic                          out_adv_reg;

    logic [ntpdr_pkg::START_W-1:0] day_ext;
    logic [ntpdr_pkg::START_W-1:0] days_add;
    logic [ntpdr_pkg::TIME_W-1:0]  time_ms;
    logic                          advanced;

    assign day_ext = {1'b0, day_of_month};

    // day offset and month rollover
    always_comb begin
        start_day_next  = start_day_reg;
        day_offset_next = day_offset_reg;
        prior_next      = prior_reg;
        days_add        = '0;
        if (start_day_reg == ntpdr_pkg::DAY_UNSET) begin
            if (day_of_month != 5'd0) begin
                start_day_next  = day_ext;
                day_offset_next = '0;
                prior_next      = '0;
            end
        end else if (day_ext < start_day_reg) begin
            prior_next      = (day_offset_reg == ntpdr_pkg::OFFSET_MAX)
                            ? ntpdr_pkg::OFFSET_MAX : 5'(day_offset_reg + 5'd1);
            day_offset_next = '0;
            start_day_next  = day_ext;
            days_add        = 6'(prior_next);
        end else begin
            day_offset_next = 5'(day_of_month - start_day_reg[4:0]);
            days_add        = 6'(6'(day_offset_next) + 6'(prior_reg));
        end
        time_ms  = 33'(33'(snap.tod) + 33'(days_add) * ntpdr_pkg::MS_PER_DAY);
        advanced = (time_ms >= last_reg);
        if (!advanced) begin
            start_day_next = ntpdr_pkg::DAY_UNSET;
        end
    end

    // result beat occupancy
    always_comb begin
        out_vld_next = out_vld_reg;
        if (ctl.term_take) begin
            out_vld_next = 1'b1;
        end else if (m_tready) begin
            out_vld_next = 1'b0;
        end
    end

    // day state and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_day_reg  <= ntpdr_pkg::DAY_UNSET;
            day_offset_reg <= '0;
            prior_reg      <= '0;
            last_reg       <= '0;
            out_vld_reg    <= 1'b0;
        end else begin
            out_vld_reg <= out_vld_next;
            if (ctl.term_take) begin
                start_day_reg  <= start_day_next;
                day_offset_reg <= day_offset_next;
                prior_reg      <= prior_next;
                last_reg       <= time_ms;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (ctl.term_take) begin
            out_time_reg   <= time_ms;
            out_hour_reg   <= snap.hour;
            out_minute_reg <= snap.minute;
            out_second_reg <= snap.second;
            out_adv_reg    <= advanced;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {1'b0, out_adv_reg, out_second_reg, out_minute_reg,
                       out_hour_reg, out_time_reg};

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.term_take |-> (!out_vld_reg || m_tready))
        else $error("result beat overwritten while pending");

    // a time that went back leaves the start day unset
    a_back_unsets: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.term_take && !advanced) |=> (start_day_reg == ntpdr_pkg::DAY_UNSET))
        else $error("start day kept after time went back");

    // the start day is a real day or the unset marker
    a_start_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (start_day_reg <= 6'd31) || (start_day_reg == ntpdr_pkg::DAY_UNSET))
        else $error("start day out of range");

    // a loaded result carries the new last time
    a_last_time: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.term_take |=> (out_time_reg == last_reg))
        else $error("result time and last time differ");

endmodule

`default_nettype wire

// ----- design/nmea_time_parse_day_rollover_top.sv -----
// NMEA time field parser with day rollover.
// Throughput: one input beat per cycle unless a terminator waits on a full
// result register; the character parse and day update run between the input
// and result registers. A terminator beat goes through the input register and
// then the result register to m_tvalid; character beats give no result.
// Reset: synchronous, active low; clears parse state, day tracking and valids.
`default_nettype none

module nmea_time_parse_day_rollover_top #(
    parameter int FRACTION_DIGITS = 3
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // char_code[7:0], day_of_month[12:8], zeros
    input  wire logic        s_tlast,   // end_of_field
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata    // time_ms[32:0], hour_value[39:33],
                                        // minute_value[46:40], second_value[53:47],
                                        // time_advanced[54], zero[55]
);

    logic       in_vld_reg;
    logic [7:0] in_char_reg;
    logic [4:0] in_day_reg;
    logic       in_end_reg;

    logic                 out_free;
    logic                 advance;
    ntpdr_pkg::beat_ctl_t ctl;
    ntpdr_pkg::field_snap_t snap;

    // stage advances unless a terminator waits on a full result register
    assign out_free      = !m_tvalid || m_tready;
    assign advance       = in_vld_reg && (!in_end_reg || out_free);
    assign s_tready      = !in_vld_reg || advance;
    assign ctl.char_take = advance && !in_end_reg;
    assign ctl.term_take = advance && in_end_reg;

    // input register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_vld_reg <= 1'b1;
        end else if (advance) begin
            in_vld_reg <= 1'b0;
        end
    end

    // input register payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata[7:0];
            in_day_reg  <= s_tdata[12:8];
            in_end_reg  <= s_tlast;
        end
    end

    ntpdr_char_parse #(
        .FRACTION_DIGITS (FRACTION_DIGITS)
    ) u_char_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .char_code (in_char_reg),
        .snap      (snap)
    );

    ntpdr_day_roll u_day_roll (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctl          (ctl),
        .day_of_month (in_day_reg),
        .snap         (snap),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule

`default_nettype wire

// ----- sim/tb_nmea_time_parse_day_rollover_top.sv -----
`default_nettype none

module tb_nmea_time_parse_day_rollover_top;

    localparam int FRACTION_DIGITS = 3;
    localparam int FIELD_BEATS     = 1450;
    localparam int HOLD_CYCLES     = 300;
    localparam int HOLD_AT_BEAT    = 800;
    localparam int QUIET_FROM      = 200;
    localparam int QUIET_TO        = 500;
    localparam int GAP_PERCENT     = 6;
    localparam int DRAIN_CYCLES    = 20;
    localparam int MAX_REPORTS     = 10;

    // one beat of the time field stream
    typedef struct packed {
        logic [7:0]                  ch;
        logic                        is_term;
        logic [ntpdr_pkg::DAY_W-1:0] day;
    } nmea_beat_t;

    // one parsed time stamp
    typedef struct packed {
        logic [ntpdr_pkg::TIME_W-1:0] time_ms;
        logic [ntpdr_pkg::PAIR_W-1:0] hour;
        logic [ntpdr_pkg::PAIR_W-1:0] minute;
        logic [ntpdr_pkg::PAIR_W-1:0] second;
        logic                         advanced;
    } time_fix_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;     // char_code[7:0], day_of_month[12:8], zeros
    logic        s_tlast  = 1'b0;   // end_of_field
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;           // time_ms[32:0], hour[39:33], minute[46:40],
                                    // second[53:47], time_advanced[54], zero[55]

    nmea_time_parse_day_rollover_top #(
        .FRACTION_DIGITS(FRACTION_DIGITS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    nmea_beat_t field_beats[$];
    time_fix_t  expected_times[$];

    int beats_taken     = 0;
    int fixes_checked   = 0;
    int mismatches      = 0;
    int backward_steps  = 0;
    int month_changes   = 0;

    // parser state of the predictor
    logic [ntpdr_pkg::POS_W-1:0]   pos_cnt;
    logic [4:0]                    digit_hold;
    logic [ntpdr_pkg::PAIR_W-1:0]  hh, mm, ss;
    logic [9:0]                    frac_ms;
    logic [ntpdr_pkg::COUNT_W-1:0] frac_cnt;
    logic                          frac_on;
    // day tracking of the predictor
    logic [ntpdr_pkg::START_W-1:0] first_day;
    logic [ntpdr_pkg::DAY_W-1:0]   days_into_month;
    logic [ntpdr_pkg::DAY_W-1:0]   days_prior_months;
    logic [ntpdr_pkg::TIME_W-1:0]  prev_time;

    // receiver hold-off
    logic hold_active = 1'b0;
    logic hold_done   = 1'b0;
    int   hold_cycles = 0;

    function automatic void clear_field_parse();
        pos_cnt    = '0;
        digit_hold = '0;
        hh         = '0;
        mm         = '0;
        ss         = '0;
        frac_ms    = '0;
        frac_cnt   = '0;
        frac_on    = 1'b0;
    endfunction

    function automatic void reset_time_tracking();
        clear_field_parse();
        first_day         = ntpdr_pkg::DAY_UNSET;
        days_into_month   = '0;
        days_prior_months = '0;
        prev_time         = '0;
    endfunction

    // one character of the field into the parse state
    function automatic void take_field_char(input logic [7:0] c);
        logic                         dig;
        logic [3:0]                   d;
        logic [ntpdr_pkg::PAIR_W-1:0] pair;
        int unsigned                  weight;
        dig = (c >= ntpdr_pkg::CHAR_ZERO) && (c <= ntpdr_pkg::CHAR_NINE);
        d   = 4'(c - ntpdr_pkg::CHAR_ZERO);
        if (pos_cnt < ntpdr_pkg::POS_PAIRS) begin
            if (!pos_cnt[0]) begin
                digit_hold = dig ? {1'b1, d} : 5'd0;
            end else begin
                pair = (digit_hold[4] && dig) ? 7'(digit_hold[3:0] * 10 + d) : 7'd0;
                case (pos_cnt)
                    ntpdr_pkg::POS_HOUR:   hh = pair;
                    ntpdr_pkg::POS_MINUTE: mm = pair;
                    default:               ss = pair;
                endcase
            end
        end else if (pos_cnt == ntpdr_pkg::POS_DOT) begin
            frac_on = (c == ntpdr_pkg::CHAR_DOT);
        end else if (frac_on) begin
            if (dig) begin
                if (frac_cnt < FRACTION_DIGITS) begin
                    // digits past the third fall below a millisecond
                    weight  = (frac_cnt == 0) ? 100 : (frac_cnt == 1) ? 10 :
                              (frac_cnt == 2) ? 1 : 0;
                    frac_ms = 10'(frac_ms + d * weight);
                    frac_cnt++;
                end
            end else begin
                frac_on = 1'b0;
            end
        end
        if (pos_cnt != ntpdr_pkg::POS_MAX)
            pos_cnt++;
    endfunction

    // terminator: build the time stamp and update the day tracking
    function automatic void close_time_field(input logic [ntpdr_pkg::DAY_W-1:0] day);
        time_fix_t   fix;
        logic [63:0] t;
        fix = '0;
        t   = '0;
        if (pos_cnt >= ntpdr_pkg::POS_PAIRS) begin
            fix.hour   = hh;
            fix.minute = mm;
            fix.second = ss;
            t = (64'(ss) + 64'(mm) * 60 + 64'(hh) * 3600) * 1000 + 64'(frac_ms);
        end
        if (first_day == ntpdr_pkg::DAY_UNSET) begin
            if (day != 0) begin
                first_day         = {1'b0, day};
                days_into_month   = '0;
                days_prior_months = '0;
            end
        end else begin
            if ({1'b0, day} < first_day) begin
                days_prior_months = (days_into_month == ntpdr_pkg::OFFSET_MAX)
                                  ? ntpdr_pkg::OFFSET_MAX : days_into_month + 1'b1;
                days_into_month   = '0;
                first_day         = {1'b0, day};
                month_changes++;
            end else begin
                days_into_month = 5'(day - first_day);
            end
            t = t + (64'(days_into_month) + 64'(days_prior_months))
                  * 64'(ntpdr_pkg::MS_PER_DAY);
        end
        if (t < 64'(prev_time)) begin
            first_day    = ntpdr_pkg::DAY_UNSET;
            fix.advanced = 1'b0;
            backward_steps++;
        end else begin
            fix.advanced = 1'b1;
        end
        prev_time   = t[ntpdr_pkg::TIME_W-1:0];
        fix.time_ms = t[ntpdr_pkg::TIME_W-1:0];
        expected_times.push_back(fix);
        clear_field_parse();
    endfunction

    function automatic void flag_mismatch(input string what, input logic [63:0] want,
                                          input logic [63:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch on %s: expected %0d, got %0d (result %0d)",
                     what, want, got, fixes_checked);
    endfunction

    task automatic push_beat(input logic [7:0] ch, input logic is_term,
                             input logic [ntpdr_pkg::DAY_W-1:0] day);
        nmea_beat_t b;
        b.ch      = ch;
        b.is_term = is_term;
        b.day     = day;
        field_beats.push_back(b);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_beat(s[i], 1'b0, 5'($urandom_range(31)));
    endtask

    task automatic push_term(input logic [ntpdr_pkg::DAY_W-1:0] day);
        push_beat(8'($urandom_range(255)), 1'b1, day);
    endtask

    task automatic push_digit();
        push_beat(8'(ntpdr_pkg::CHAR_ZERO + $urandom_range(9)), 1'b0,
                  5'($urandom_range(31)));
    endtask

    task automatic push_any_char();
        push_beat(8'($urandom_range(255)), 1'b0, 5'($urandom_range(31)));
    endtask

    // mostly well-formed fields, some broken ones and some noise
    task automatic push_random_field(inout logic [ntpdr_pkg::DAY_W-1:0] cur_day);
        int kind;
        int n;
        int pick;
        kind = $urandom_range(99);
        if (kind < 75) begin
            for (int i = 0; i < 6; i++)
                push_digit();
            if ($urandom_range(99) < 60) begin
                push_beat(ntpdr_pkg::CHAR_DOT, 1'b0, 5'($urandom_range(31)));
                n = $urandom_range(6);
                for (int i = 0; i < n; i++)
                    push_digit();
            end
            if ($urandom_range(99) < 20) begin
                n = $urandom_range(3);
                for (int i = 0; i < n; i++)
                    push_any_char();
            end
            if ($urandom_range(99) < 5) begin
                // run past the saturating position counter
                n = $urandom_range(10, 14);
                for (int i = 0; i < n; i++)
                    push_digit();
            end
        end else if (kind < 90) begin
            n = $urandom_range(8);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(1))
                    push_digit();
                else
                    push_any_char();
            end
        end else begin
            n = $urandom_range(18);
            for (int i = 0; i < n; i++)
                push_any_char();
        end

        // date day: mostly steady, sometimes the next day, a random day or a jump back
        pick = $urandom_range(99);
        if (pick < 65)
            cur_day = cur_day;
        else if (pick < 80)
            cur_day = (cur_day == 5'd31) ? 5'd1 : cur_day + 1'b1;
        else if (pick < 90)
            cur_day = 5'($urandom_range(31));
        else
            cur_day = 5'($urandom_range(cur_day));
        push_term(cur_day);
    endtask

    // clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // input driver, valid held until the beat is taken
    always @(posedge aclk) begin : drive
        nmea_beat_t nb;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            reset_time_tracking();
        end else begin
            if (s_tvalid && s_tready) begin
                if (s_tlast)
                    close_time_field(s_tdata[12:8]);
                else
                    take_field_char(s_tdata[7:0]);
                beats_taken <= beats_taken + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (field_beats.size() != 0 &&
                    !((beats_taken < QUIET_FROM || beats_taken >= QUIET_TO) &&
                      $urandom_range(99) < GAP_PERCENT)) begin
                    nb = field_beats.pop_front();
                    s_tdata  <= {3'b000, nb.day, nb.ch};
                    s_tlast  <= nb.is_term;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, once, while the sender keeps going
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_active <= 1'b0;
            hold_done   <= 1'b0;
            hold_cycles <= 0;
        end else if (hold_active) begin
            if (hold_cycles == HOLD_CYCLES - 1) begin
                hold_active <= 1'b0;
                hold_done   <= 1'b1;
            end
            hold_cycles <= hold_cycles + 1;
        end else if (!hold_done && beats_taken >= HOLD_AT_BEAT) begin
            hold_active <= 1'b1;
        end
    end

    // result monitor and checker
    always @(posedge aclk) begin : watch
        time_fix_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_times.size() == 0) begin
                    flag_mismatch("unexpected result beat, time_ms", 64'd0,
                                  64'(m_tdata[32:0]));
                end else begin
                    want = expected_times.pop_front();
                    if (m_tdata[32:0] !== want.time_ms)
                        flag_mismatch("time_ms", 64'(want.time_ms), 64'(m_tdata[32:0]));
                    if (m_tdata[39:33] !== want.hour)
                        flag_mismatch("hour_value", 64'(want.hour), 64'(m_tdata[39:33]));
                    if (m_tdata[46:40] !== want.minute)
                        flag_mismatch("minute_value", 64'(want.minute), 64'(m_tdata[46:40]));
                    if (m_tdata[53:47] !== want.second)
                        flag_mismatch("second_value", 64'(want.second), 64'(m_tdata[53:47]));
                    if (m_tdata[54] !== want.advanced)
                        flag_mismatch("time_advanced", 64'(want.advanced), 64'(m_tdata[54]));
                    fixes_checked++;
                end
            end
            m_tready <= !hold_active &&
                        !((beats_taken < QUIET_FROM || beats_taken >= QUIET_TO) &&
                          $urandom_range(99) < GAP_PERCENT);
        end
    end

    // stimulus and end of run
    initial begin : stimulus
        logic [ntpdr_pkg::DAY_W-1:0] cur_day;

        // directed: lone terminator with no date, full field with a long fraction
        // on the first date, short field across a month change, non-digit and
        // extreme codes in the pairs
        push_term(5'd0);
        push_text("235959.9999");
        push_term(5'd31);
        push_text("0000");
        push_term(5'd1);
        push_beat(8'h00, 1'b0, 5'd31);
        push_beat(8'hFF, 1'b0, 5'd0);
        push_text("1234");
        push_term(5'd1);

        cur_day = 5'd1;
        while (field_beats.size() < FIELD_BEATS)
            push_random_field(cur_day);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (field_beats.size() != 0 || s_tvalid || expected_times.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (expected_times.size() != 0)
            flag_mismatch("results never delivered", 64'(expected_times.size()), 64'd0);

        $display("%0d beats taken, %0d time stamps checked", beats_taken, fixes_checked);
        $display("%0d went backward, %0d month changes, one %0d-cycle receiver hold-off",
                 backward_steps, month_changes, HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("simulation failed");
        end
        $finish;
    end

    // guard against a hung handshake
    initial begin
        #2000000;
        $display("timeout with %0d results outstanding", expected_times.size());
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
